// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, constants and helpers for the text console writer.
// No dependencies; imported by tcw_ctrl and text_console_writer.
package tcw_pkg;

   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 25;
   localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(CELL_COUNT);

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;

   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

   localparam logic [COL_W-1:0] ROW_WIDTH_RESET = 7'd80;
   localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 5'd25;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic {
      REG_ROW_WIDTH = 1'b0,
      REG_ROW_COUNT = 1'b1
   } reg_index_type;

   // Clamped geometry, as last used column and last used row.
   typedef struct packed {
      logic [COL_W-1:0] last_col;
      logic [ROW_W-1:0] last_row;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLUMNS));
      return base + ADDR_W'(col);
   endfunction

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Simple dual-port screen memory: one write port, one read port with registered data.
// No dependencies.
module tcw_ram #(
   parameter int DEPTH  = 2000,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Request sequencer: cursor, put/read handling, scroll and clear sweeps,
// power-up clearing pass and response register. Uses tcw_pkg; drives tcw_ram.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,
   input  logic [31:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output ram_req_type       ram_req,
   input  logic [CELL_W-1:0] ram_rdata
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_COPY,
      S_DRAIN,
      S_BLANK,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] init_addr_ff, init_addr_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  sw_row_ff, sw_row_in;
   logic [COL_W-1:0]  sw_col_ff, sw_col_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              oob_ff, oob_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              scroll_ff, scroll_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;

   op_type            op;
   logic [CHAR_W-1:0] ch;
   logic [CHAR_W-1:0] color;
   logic [ROW_W-1:0]  read_row;
   logic [COL_W-1:0]  read_col;
   logic              req_fire;

   logic [ROW_W-1:0]  sat_row, put_row;
   logic [COL_W-1:0]  sat_col, put_col;
   logic              wrap, put_scroll;
   logic              sweep_last_col;

   assign op       = op_type'(req_tuser);
   assign ch       = req_tdata[7:0];
   assign color    = req_tdata[15:8];
   assign read_row = req_tdata[20:16];
   assign read_col = req_tdata[27:21];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Put: saturate the cursor into the used area, then step it.
   always_comb begin
      sat_row    = (cur_row_ff > cfg.last_row) ? cfg.last_row : cur_row_ff;
      sat_col    = (cur_col_ff > cfg.last_col) ? cfg.last_col : cur_col_ff;
      wrap       = (ch == NEWLINE_CHAR) || (sat_col == cfg.last_col);
      put_col    = wrap ? '0 : sat_col + COL_W'(1);
      put_scroll = wrap && (sat_row == cfg.last_row);
      put_row    = (wrap && !put_scroll) ? sat_row + ROW_W'(1) : sat_row;
   end

   assign sweep_last_col = (sw_col_ff == cfg.last_col);

   always_comb begin
      state_in        = state_ff;
      init_addr_in    = init_addr_ff;
      cur_row_in      = cur_row_ff;
      cur_col_in      = cur_col_ff;
      sw_row_in       = sw_row_ff;
      sw_col_in       = sw_col_ff;
      wr_pend_in      = 1'b0;
      wr_addr_in      = wr_addr_ff;
      oob_in          = oob_ff;
      cell_in         = cell_ff;
      scroll_in       = scroll_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_cell_in     = rsp_cell_ff;
      rsp_scrolled_in = rsp_scrolled_ff;

      ram_req.we    = 1'b0;
      ram_req.waddr = '0;
      ram_req.wdata = BLANK_CELL;
      ram_req.re    = 1'b0;
      ram_req.raddr = '0;

      // Copy writes are issued in the cycle after their reads.
      if (wr_pend_ff) begin
         ram_req.we    = 1'b1;
         ram_req.waddr = wr_addr_ff;
         ram_req.wdata = ram_rdata;
      end

      unique case (state_ff)
         S_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = init_addr_ff;
            if (init_addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               init_addr_in = init_addr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cell_in   = '0;
               scroll_in = 1'b0;
               sw_row_in = '0;
               sw_col_in = '0;
               unique case (op)
                  OP_PUT: begin
                     if (ch != NEWLINE_CHAR) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = cell_addr(sat_row, sat_col);
                        ram_req.wdata = {color, ch};
                     end
                     cur_row_in = put_row;
                     cur_col_in = put_col;
                     scroll_in  = put_scroll;
                     if (!put_scroll) begin
                        state_in = S_RESP;
                     end else if (cfg.last_row == '0) begin
                        state_in = S_BLANK;
                     end else begin
                        state_in = S_COPY;
                     end
                  end
                  OP_READ: begin
                     oob_in = (read_row >= ROW_W'(MAX_ROWS)) ||
                              ({1'b0, read_col} >= (COL_W+1)'(MAX_COLUMNS));
                     ram_req.re    = !oob_in;
                     ram_req.raddr = cell_addr(read_row, read_col);
                     state_in      = S_READ;
                  end
                  OP_CLEAR: begin
                     state_in = S_BLANK;
                  end
                  OP_NONE: begin
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_READ: begin
            cell_in  = oob_ff ? '0 : ram_rdata;
            state_in = S_RESP;
         end
         S_COPY: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = cell_addr(sw_row_ff + ROW_W'(1), sw_col_ff);
            wr_pend_in    = 1'b1;
            wr_addr_in    = cell_addr(sw_row_ff, sw_col_ff);
            if (sweep_last_col) begin
               sw_col_in = '0;
               sw_row_in = sw_row_ff + ROW_W'(1);
               if (sw_row_ff == cfg.last_row - ROW_W'(1)) begin
                  state_in = S_DRAIN;
               end
            end else begin
               sw_col_in = sw_col_ff + COL_W'(1);
            end
         end
         S_DRAIN: begin
            sw_row_in = cfg.last_row;
            sw_col_in = '0;
            state_in  = S_BLANK;
         end
         S_BLANK: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cell_addr(sw_row_ff, sw_col_ff);
            if (sweep_last_col) begin
               sw_col_in = '0;
               sw_row_in = sw_row_ff + ROW_W'(1);
               if (sw_row_ff == cfg.last_row) begin
                  state_in = S_RESP;
               end
            end else begin
               sw_col_in = sw_col_ff + COL_W'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_row_in      = cur_row_ff;
               rsp_col_in      = cur_col_ff;
               rsp_cell_in     = cell_ff;
               rsp_scrolled_in = scroll_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_addr_ff <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sw_row_ff       <= sw_row_in;
      sw_col_ff       <= sw_col_in;
      wr_addr_ff      <= wr_addr_in;
      oob_ff          <= oob_in;
      cell_ff         <= cell_in;
      scroll_ff       <= scroll_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_scrolled_ff, rsp_cell_ff, rsp_col_ff, rsp_row_ff};

   a_cursor_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |->
         (cur_row_ff <= ROW_W'(MAX_ROWS - 1)) &&
         ({1'b0, cur_col_ff} <= (COL_W+1)'(MAX_COLUMNS - 1)))
      else $error("cursor left the screen store");

   a_pend_only_in_copy: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == S_COPY) || (state_ff == S_DRAIN))
      else $error("copy write pending outside a scroll");

   a_scroll_on_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |-> (rsp_row_ff == cfg.last_row))
      else $error("scrolled response with cursor off the last row");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("request accepted without leaving idle");

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Text console writer top level: register port, geometry clamping, sequencer and
// screen memory. Uses tcw_pkg, tcw_ram and tcw_ctrl.
//
// Text-mode console: a screen of 16-bit cells (attribute high byte, character low
// byte) in one single-port-write memory of MAX_ROWS x MAX_COLUMNS cells, plus a
// cursor. After reset the block blanks the whole memory, one cell a cycle, with
// req_tready low; register writes are taken at any time. One request is handled
// at a time: a read waits for the registered memory data, a clear blanks the used
// area and a scrolling put copies each used row but the first up by one and then
// blanks the last used row (with a single row it only blanks it); scroll and clear
// sweep the memory one cell per cycle.
// The finished response sits in an output register, so the next request can be
// accepted while it waits to be taken.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,   // 0 row_width, 1 row_count
   input  logic [6:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // op[1:0]
   input  logic [31:0] req_tdata,   // ch[7:0], color[15:8], read_row[20:16], read_col[27:21]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // cursor_row[4:0], cursor_col[11:5], cell_value[27:12],
                                    // scrolled[28]
);

   logic [COL_W-1:0]  row_width_ff;
   logic [ROW_W-1:0]  row_count_ff;
   cfg_type           cfg;
   ram_req_type       ram_req;
   logic [CELL_W-1:0] ram_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         row_count_ff <= ROW_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_ROW_WIDTH: row_width_ff <= csr_data;
            REG_ROW_COUNT: row_count_ff <= csr_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero acts as one, anything above the store size as the store size.
   always_comb begin
      if (row_width_ff == '0) begin
         cfg.last_col = '0;
      end else if ({1'b0, row_width_ff} > (COL_W+1)'(MAX_COLUMNS)) begin
         cfg.last_col = COL_W'(MAX_COLUMNS - 1);
      end else begin
         cfg.last_col = row_width_ff - COL_W'(1);
      end
      if (row_count_ff == '0) begin
         cfg.last_row = '0;
      end else if ({1'b0, row_count_ff} > (ROW_W+1)'(MAX_ROWS)) begin
         cfg.last_row = ROW_W'(MAX_ROWS - 1);
      end else begin
         cfg.last_row = row_count_ff - ROW_W'(1);
      end
   end

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata)
   );

   tcw_ram #(
      .DEPTH  (CELL_COUNT),
      .WIDTH  (CELL_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

endmodule
